### sv/assert_macros.svh
// Assertion macros shared by the multiset RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define OSM_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define OSM_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its cause.
`define OSM_IMPLY_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/osm_pkg.sv
// Shared types, constants and sizing functions for the order-statistic multiset.
package osm_pkg;

  localparam int DATA_W       = 32;
  localparam int RANK_W       = 9;
  localparam int COUNT_OUT_W  = 9;
  localparam int CAPACITY_DEF = 256;

  // Read tree: 16-way OR per stage
  localparam int TREE_SHIFT = 4;
  localparam int TREE_FANIN = 1 << TREE_SHIFT;

  // Item modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic                     ins;
    logic signed [DATA_W-1:0] value;
    logic [RANK_W-1:0]        rank;
  } osm_cell_ctl_t;

  // Number of nodes at a given stage of the read tree
  function automatic int tree_nodes(input int leaves, input int level);
    int n;
    n = leaves;
    for (int l = 0; l <= level; l++) begin
      n = (n + TREE_FANIN - 1) >> TREE_SHIFT;
    end
    return n;
  endfunction

  // Number of registered stages down to a single root
  function automatic int tree_levels(input int leaves);
    int n;
    int l;
    n = leaves;
    l = 0;
    do begin
      n = (n + TREE_FANIN - 1) >> TREE_SHIFT;
      l++;
    end while (n > 1);
    return l;
  endfunction

endpackage

### sv/osm_cell.sv
// One slot of the sorted chain: holds an entry and shifts on insert.
`include "assert_macros.svh"

module osm_cell #(
  parameter int CAPACITY = osm_pkg::CAPACITY_DEF,
  parameter int INDEX    = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  osm_pkg::osm_cell_ctl_t           ctl,
  input  logic [$clog2(CAPACITY+1)-1:0]    count,
  input  logic signed [osm_pkg::DATA_W-1:0] prev_entry,
  input  logic                             prev_gt,
  output logic signed [osm_pkg::DATA_W-1:0] entry,
  output logic                             gt,
  output logic [osm_pkg::DATA_W-1:0]       leaf
);
  import osm_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic occ;
  logic at_tail;
  logic picked;

  // Slot holds a live entry / slot is the first free one
  assign occ     = CW'(INDEX) < count;
  assign at_tail = count == CW'(INDEX);

  // Entry lies above the incoming value
  assign gt = occ && ($signed(entry) > $signed(ctl.value));

  // Gate this entry onto the read tree when its rank is asked for
  assign picked = (32'(ctl.rank) == 32'(INDEX + 1));
  assign leaf   = picked ? entry : '0;

  // Shift up from the neighbor, or take the new value at the insertion point
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (prev_gt) begin
        entry <= prev_entry;
      end else if (gt || at_tail) begin
        entry <= ctl.value;
      end
    end
  end

  `OSM_IMPLY(a_sorted, occ && (INDEX > 0), $signed(prev_entry) <= $signed(entry), "cell out of order")
  `OSM_IMPLY_NEXT(a_hold, occ && !ctl.ins, $stable(entry), "live entry changed without insert")
  `OSM_IMPLY_NEXT(a_place, ctl.ins && at_tail && !prev_gt, entry == $past(ctl.value), "tail missed value")

endmodule

### sv/osm_or_tree.sv
// Registered 16-way OR tree that collects the selected cell onto one root.
module osm_or_tree #(
  parameter int LEAVES = osm_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic [osm_pkg::DATA_W-1:0]   leaves [LEAVES],
  output logic [osm_pkg::DATA_W-1:0]   root
);
  import osm_pkg::*;

  localparam int LEVELS = tree_levels(LEAVES);
  localparam int N0     = tree_nodes(LEAVES, 0);

  logic [DATA_W-1:0] nodes [LEVELS][N0];

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    localparam int NIN  = (l == 0) ? LEAVES : tree_nodes(LEAVES, l - 1);
    localparam int NOUT = tree_nodes(LEAVES, l);

    for (genvar n = 0; n < NOUT; n++) begin : g_node
      logic [DATA_W-1:0] kids [TREE_FANIN];
      logic [DATA_W-1:0] merged;

      // Route children, pad past the end with zero
      for (genvar c = 0; c < TREE_FANIN; c++) begin : g_kid
        if (n * TREE_FANIN + c < NIN) begin : g_live
          if (l == 0) begin : g_leaf
            assign kids[c] = leaves[n * TREE_FANIN + c];
          end else begin : g_inner
            assign kids[c] = nodes[l - 1][n * TREE_FANIN + c];
          end
        end else begin : g_pad
          assign kids[c] = '0;
        end
      end

      // Merge children
      always_comb begin
        merged = '0;
        for (int c = 0; c < TREE_FANIN; c++) begin
          merged = merged | kids[c];
        end
      end

      // Register the stage
      always_ff @(posedge clk) begin
        nodes[l][n] <= merged;
      end
    end
  end

  assign root = nodes[LEVELS - 1][0];

endmodule

### sv/order_statistic_multiset.sv
// Sorted multiset of signed 32-bit values: insert, query by rank, clear.
// Insert and clear: result registered at the accept edge, one item per cycle while the output is not stalled.
// Query: the rank is registered, then the selected cell is brought to the output by the
// registered 16-way OR tree, and its root is registered into the result.
// Input is stalled while a query walks the tree or a result waits on the output.
// Reset clears the entry count and control; stored entries are not cleared.
`include "assert_macros.svh"

module order_statistic_multiset #(
  parameter int CAPACITY = osm_pkg::CAPACITY_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             mode,
  input  logic signed [osm_pkg::DATA_W-1:0]      value,
  input  logic [osm_pkg::RANK_W-1:0]             rank,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [osm_pkg::DATA_W-1:0]      result_value,
  output logic                                   found,
  output logic                                   rejected,
  output logic [osm_pkg::COUNT_OUT_W-1:0]        stored_count
);
  import osm_pkg::*;

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int LW     = $clog2(LEVELS + 1);

  localparam logic signed [DATA_W-1:0] NOT_FOUND_VALUE = {DATA_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_QUERY = 2'b10
  } osm_state_t;

  osm_state_t          state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [LW-1:0]       lat_cnt;
  logic [RANK_W-1:0]   rank_q;
  logic                found_q;
  logic                in_acc;
  logic                full;
  logic                rank_hit;
  logic                out_load;
  osm_cell_ctl_t       ctl;

  logic signed [DATA_W-1:0] chain_entry [CAPACITY + 1];
  logic                     chain_gt    [CAPACITY + 1];
  logic [DATA_W-1:0]        leaf_w      [CAPACITY];
  logic [DATA_W-1:0]        root;

  // Handshake
  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;

  assign full     = count == CW'(CAPACITY);
  assign rank_hit = (rank != '0) && (32'(rank) <= 32'(count));

  // Load the output register when a result is ready
  assign out_load = ((state == ST_IDLE) && in_acc && (mode != MODE_QUERY)) ||
                    ((state == ST_QUERY) && (lat_cnt == LW'(LEVELS)));

  // Broadcast to the chain
  assign ctl.ins   = in_acc && (mode == MODE_INSERT) && !full;
  assign ctl.value = value;
  assign ctl.rank  = rank_q;

  // Count after this beat
  always_comb begin
    count_next = count;
    if (in_acc) begin
      case (mode)
        MODE_INSERT: if (!full) count_next = count + 1'b1;
        MODE_CLEAR:  count_next = '0;
        default:     count_next = count;
      endcase
    end
  end

  // Chain of cells, slot zero at the head
  assign chain_entry[0] = '0;
  assign chain_gt[0]    = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    osm_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .count      (count),
      .prev_entry (chain_entry[i]),
      .prev_gt    (chain_gt[i]),
      .entry      (chain_entry[i + 1]),
      .gt         (chain_gt[i + 1]),
      .leaf       (leaf_w[i])
    );
  end

  osm_or_tree #(
    .LEAVES (CAPACITY)
  ) u_tree (
    .clk    (clk),
    .leaves (leaf_w),
    .root   (root)
  );

  // Control, count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      lat_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      // Raise valid on a new result, drop it once the beat is taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (mode == MODE_QUERY) begin
              // Hold rank for the cells and walk the tree
              state   <= ST_QUERY;
              lat_cnt <= '0;
              rank_q  <= rank;
              found_q <= rank_hit;
            end else begin
              result_value <= '0;
              found        <= 1'b0;
              rejected     <= (mode == MODE_INSERT) && full;
              stored_count <= COUNT_OUT_W'(count_next);
            end
          end
        end
        ST_QUERY: begin
          lat_cnt <= lat_cnt + 1'b1;
          if (lat_cnt == LW'(LEVELS)) begin
            state        <= ST_IDLE;
            result_value <= found_q ? $signed(root) : NOT_FOUND_VALUE;
            found        <= found_q;
            rejected     <= 1'b0;
            stored_count <= COUNT_OUT_W'(count);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `OSM_ASSERT(a_count_bound, count <= CW'(CAPACITY), "entry count above capacity")
  `OSM_IMPLY_NEXT(a_ins_grow, ctl.ins, count == $past(count) + 1'b1, "insert did not grow count")
  `OSM_IMPLY_NEXT(a_clear, in_acc && (mode == MODE_CLEAR), count == '0, "clear left entries")
  `OSM_IMPLY(a_lat_bound, state == ST_QUERY, lat_cnt <= LW'(LEVELS), "query walk overran tree")

endmodule

### bench/order_statistic_multiset_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the sorted multiset: directed cases, a full store and random traffic.
module order_statistic_multiset_test;
  import osm_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int MAX_WAIT = 6;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int TOTAL_ITEMS = 1200;
  localparam int MAX_REPORTS = 10;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] NOT_FOUND = -1;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     found;
    logic                     rejected;
    logic [COUNT_OUT_W-1:0]   count;
  } multiset_result_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] mode;
  logic signed [DATA_W-1:0] value;
  logic [RANK_W-1:0] rank;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] result_value;
  logic found;
  logic rejected;
  logic [COUNT_OUT_W-1:0] stored_count;

  // Shadow copy of the sorted store and its fill level
  logic signed [DATA_W-1:0] sorted_vals [CAP];
  int held = 0;
  multiset_result_t expected_results[$];

  int mismatches = 0;
  int results_seen = 0;
  int hold_mark = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  bit sender_burst;
  bit recv_burst;

  order_statistic_multiset #(
    .CAPACITY(CAP)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .value(value),
    .rank(rank),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_value(result_value),
    .found(found),
    .rejected(rejected),
    .stored_count(stored_count)
  );

  always #2 clk = ~clk;

  // Apply one beat to the shadow store and return what the block should answer
  function automatic multiset_result_t apply_item(input logic [1:0] m,
                                                  input logic signed [DATA_W-1:0] v,
                                                  input logic [RANK_W-1:0] r);
    multiset_result_t res;
    int pos;
    res = '0;
    case (m)
      MODE_INSERT: begin
        if (held >= CAP) begin
          res.rejected = 1'b1;
        end else begin
          // shift larger entries up; equal values stay ahead of the new one
          pos = held;
          while (pos > 0 && sorted_vals[pos-1] > v) begin
            sorted_vals[pos] = sorted_vals[pos-1];
            pos--;
          end
          sorted_vals[pos] = v;
          held++;
        end
      end
      MODE_QUERY: begin
        if (r >= 1 && r <= held) begin
          res.value = sorted_vals[r-1];
          res.found = 1'b1;
        end else begin
          res.value = NOT_FOUND;
        end
      end
      MODE_CLEAR: begin
        held = 0;
      end
      default: begin
      end
    endcase
    res.count = held[COUNT_OUT_W-1:0];
    return res;
  endfunction

  // Present one beat after a random gap (none in a burst) and hold it until taken
  task automatic send_item(input logic [1:0] m, input logic signed [DATA_W-1:0] v,
                           input logic [RANK_W-1:0] r);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    value <= v;
    rank <= r;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(apply_item(m, v, r));
    items_sent++;
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_value(input int style);
    case (style)
      0: return $urandom_range(0, 7) - 4;
      1: begin
        case ($urandom_range(0, 4))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 0;
          3: return -1;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input multiset_result_t want,
                                 input multiset_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch (%s): expected value=%0d found=%0b rejected=%0b count=%0d",
               what, want.value, want.found, want.rejected, want.count);
      $display("  got value=%0d found=%0b rejected=%0b count=%0d",
               got.value, got.found, got.rejected, got.count);
    end
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    multiset_result_t got;
    multiset_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      got = {result_value, found, rejected, stored_count};
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) report_mismatch("field", want, got);
      end
    end
  end

  // Stall the result side for a random number of cycles after each beat, unless in a burst
  always @(negedge clk) begin
    if (results_seen != hold_mark) begin
      hold_mark = results_seen;
      stall_left = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
    end
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("order_statistic_multiset_test: FAIL");
      $finish;
    end
  end

  // Extremes, duplicates, every mode, and the out-of-range ranks
  task automatic test_directed_cases();
    send_item(MODE_QUERY, 0, 1);
    send_item(MODE_INSERT, 0, 0);
    send_item(MODE_INSERT, VAL_MAX, 9'h1ff);
    send_item(MODE_INSERT, VAL_MIN, 0);
    send_item(MODE_INSERT, -1, 0);
    send_item(MODE_INSERT, 5, 0);
    send_item(MODE_INSERT, 5, 0);
    for (int k = 1; k <= 6; k++) send_item(MODE_QUERY, 32'sh5a5a_5a5a, RANK_W'(k));
    send_item(MODE_QUERY, VAL_MAX, 0);
    send_item(MODE_QUERY, 0, 7);
    send_item(MODE_QUERY, 0, 9'h1ff);
    send_item(MODE_QUERY, 0, 9'h100);
    send_item(MODE_UNUSED, -1, 9'h1ff);
    send_item(MODE_CLEAR, VAL_MIN, 9'h1ff);
    send_item(MODE_QUERY, 0, 1);
    send_item(MODE_INSERT, 7, 0);
    send_item(MODE_QUERY, 0, 1);
  endtask

  // Fill to capacity back to back, then hit the full-store and rank limits
  task automatic test_full_store();
    drain_results();
    send_item(MODE_CLEAR, 0, 0);
    sender_burst = 1'b1;
    recv_burst = 1'b1;
    for (int k = 0; k < CAP; k++) send_item(MODE_INSERT, rand_value(k % 3), RANK_W'($urandom));
    sender_burst = 1'b0;
    recv_burst = 1'b0;
    send_item(MODE_INSERT, VAL_MAX, 0);
    send_item(MODE_INSERT, VAL_MIN, 0);
    send_item(MODE_QUERY, 0, 1);
    send_item(MODE_QUERY, 0, 9'h100);
    send_item(MODE_QUERY, 0, 128);
    send_item(MODE_QUERY, 0, 9'h101);
    send_item(MODE_QUERY, 0, 9'h1ff);
    send_item(MODE_QUERY, 0, 0);
    send_item(MODE_UNUSED, $urandom, RANK_W'($urandom));
    sender_burst = 1'b1;
    send_item(MODE_QUERY, 0, 9'h100);
    send_item(MODE_CLEAR, 0, 0);
    sender_burst = 1'b0;
  endtask

  // Episodes of fills and queries with random content, plus noise
  task automatic test_random_traffic();
    int target;
    int len;
    int pick;
    int style;
    logic [RANK_W-1:0] r;
    while (items_sent < TOTAL_ITEMS) begin
      style = $urandom_range(0, 2);
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(CAP - 4, CAP + 8)
                                           : $urandom_range(1, 40);
      len = target * 2 + $urandom_range(2, 20);
      // trim the last episode so the run lands on the item budget
      if (len > TOTAL_ITEMS - items_sent) len = TOTAL_ITEMS - items_sent;
      sender_burst = ($urandom_range(0, 4) == 0);
      recv_burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) drain_results();
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          send_item(MODE_UNUSED, $urandom, RANK_W'($urandom));
        end else if (pick < 5 && target <= 40) begin
          send_item(MODE_CLEAR, $urandom, RANK_W'($urandom));
        end else if (pick < 55 && held < target) begin
          send_item(MODE_INSERT, rand_value(style), RANK_W'($urandom));
        end else begin
          // mostly ranks around the fill level, sometimes any 9-bit rank
          if ($urandom_range(0, 4) == 0) r = RANK_W'($urandom);
          else r = RANK_W'($urandom_range(1, held + 2));
          send_item(MODE_QUERY, $urandom, r);
        end
      end
      if ($urandom_range(0, 1) == 0) send_item(MODE_CLEAR, $urandom, RANK_W'($urandom));
    end
    sender_burst = 1'b0;
    recv_burst = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_INSERT;
    value = '0;
    rank = '0;
    sender_burst = 1'b0;
    recv_burst = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_full_store();
    test_random_traffic();

    // drop valid, drain, then let the pipeline settle
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("order_statistic_multiset_test: PASS");
    else
      $display("order_statistic_multiset_test: FAIL");
    $finish;
  end

endmodule
